### rtl/access_pattern_detector_predictor_core_defines.svh
// Assertion macros used by the checker file
`ifndef ACCESS_PATTERN_DETECTOR_PREDICTOR_CORE_DEFINES_SVH
`define ACCESS_PATTERN_DETECTOR_PREDICTOR_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define APD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define APD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/apd_pkg.sv
// Shared types and constants of the access pattern detector
`default_nettype none
package apd_pkg;
    localparam int SESSIONS    = 8;
    localparam int HISTORY     = 16;
    localparam int MAX_PREDICT = 16;
    localparam int SW = $clog2(SESSIONS);
    localparam int HW = $clog2(HISTORY);
    localparam int CW = $clog2(HISTORY + 1);
    localparam int PW = $clog2(MAX_PREDICT + 1);
    localparam int MW = (PW > CW) ? PW : CW;
    localparam int AW = SW + HW;

    localparam logic [1:0] FUNC_RECORD  = 2'd0;
    localparam logic [1:0] FUNC_PREDICT = 2'd1;
    localparam logic [1:0] FUNC_RESET   = 2'd2;

    localparam logic [1:0] PAT_RANDOM   = 2'd0;
    localparam logic [1:0] PAT_SEQ      = 2'd1;
    localparam logic [1:0] PAT_STRIDE   = 2'd2;
    localparam logic [1:0] PAT_TEMPORAL = 2'd3;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_MINLEN = 2'd1;
    localparam logic [1:0] REG_RECENT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_W, ST_OUTER, ST_OUTER_W, ST_INNER, ST_INNER_W,
        ST_DECIDE, ST_TEMP, ST_TEMP_W, ST_EMIT, ST_EMIT_W
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch the item
        logic do_record;  // write one entry and update the slot
        logic do_clear;   // clear the slot
        logic rd_req;     // issue a memory read at rd_k
        logic rd_inner;   // read address comes from the inner index
        logic clr_run;    // restart counters for a pass
        logic seq_acc;    // fold read data into sequential/step scan
        logic outer_acc;  // latch outer step candidate
        logic inner_acc;  // fold inner compare
        logic outer_end;  // settle best after an inner pass
        logic temp_acc;   // count one recent entry
        logic emit;       // drive one result beat
        logic adv;        // advance scan index
        logic adv_outer;  // settle the pattern and set up the emit pass
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic too_short;
        logic scan_done;
        logic outer_done;
        logic inner_done;
        logic seq_hit;
        logic stride_hit;
        logic temp_hit;
        logic emit_done;
    } t_sts;
endpackage
`default_nettype wire

### rtl/apd_datapath.sv
// Datapath: history memories, slot state, classification and prediction
`default_nettype none
module apd_datapath import apd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [2:0]  i_session_index,
    input  wire logic [31:0] i_position,
    input  wire logic [4:0]  i_predict_count,
    input  wire logic [31:0] i_now_seconds,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic [1:0]       o_pattern,
    output logic [31:0]      o_predicted_position,
    output logic             o_position_valid,
    output logic             o_last
);
    logic [31:0] mem_pos [SESSIONS*HISTORY];
    logic [31:0] mem_tim [SESSIONS*HISTORY];
    logic [CW-1:0] r_cnt [SESSIONS];
    logic [HW-1:0] r_old [SESSIONS];
    logic [4:0]  r_win, r_min;
    logic [15:0] r_recent;
    logic [SW-1:0] r_s;
    logic [31:0] r_pos, r_now;
    logic [PW-1:0] r_want;
    logic [31:0] r_rpos, r_rtim, r_prev, r_last, r_cand, r_best, r_acc;
    logic [CW-1:0] r_k, r_j, r_run, r_c, r_bestc, r_rec, r_i;
    logic [CW-1:0] n_k;
    logic r_seq, r_lastpos_ok;
    logic [1:0] r_pat;
    logic [PW-1:0] r_n;

    // effective configuration values
    logic [CW-1:0] eff_win, eff_min, cnt;
    logic [HW-1:0] old;
    always_comb begin
        if (r_win == 5'd0) eff_win = CW'(1);
        else if (32'(r_win) > 32'(HISTORY)) eff_win = CW'(HISTORY);
        else eff_win = CW'(r_win);
        eff_min = (r_min == 5'd0) ? CW'(1) : CW'(r_min);
        cnt = r_cnt[r_s];
        old = r_old[r_s];
    end

    // read address: inner pass, newest-first emit, or scan index
    logic [CW-1:0] rd_k;
    always_comb begin
        if (i_cmd.rd_inner) rd_k = r_j - CW'(1);
        else if (r_pat == PAT_TEMPORAL) rd_k = cnt - CW'(1) - r_i;
        else rd_k = r_k;
    end
    logic [HW-1:0] ring;
    assign ring = old + rd_k[HW-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 5'd16; r_min <= 5'd3; r_recent <= 16'd60;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW: r_win <= i_cfg_data[4:0];
                REG_MINLEN: r_min <= i_cfg_data[4:0];
                REG_RECENT: r_recent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memory write and registered read
    logic [HW-1:0] wr_ring;
    assign wr_ring = (32'(cnt) >= 32'(HISTORY)) ? old : old + cnt[HW-1:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_record) begin
            mem_pos[{r_s, wr_ring}] <= r_pos;
            mem_tim[{r_s, wr_ring}] <= r_now;
        end
        if (i_cmd.rd_req) begin
            r_rpos <= mem_pos[{r_s, ring}];
            r_rtim <= mem_tim[{r_s, ring}];
        end
    end

    // slot counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SESSIONS; s++) begin
                r_cnt[s] <= '0; r_old[s] <= '0;
            end
        end else if (i_cmd.do_clear) begin
            r_cnt[r_s] <= '0; r_old[r_s] <= '0;
        end else if (i_cmd.do_record) begin
            if (32'(cnt) >= 32'(HISTORY)) begin
                r_old[r_s] <= old + HW'(1);
            end else if (cnt + CW'(1) > eff_win) begin
                r_old[r_s] <= old + HW'(1);
            end else begin
                r_cnt[r_s] <= cnt + CW'(1);
            end
        end
    end

    // classification scratch
    logic [31:0] diff;
    logic [31:0] age;
    logic        is_recent;
    assign diff = r_rpos - r_prev;
    assign age  = (r_now >= r_rtim) ? r_now - r_rtim : 32'd0;
    assign is_recent = (age < 32'(r_recent));
    assign n_k  = r_k + CW'(1);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= i_session_index[SW-1:0];
            r_pos <= i_position; r_now <= i_now_seconds;
            r_want <= (32'(i_predict_count) > 32'(MAX_PREDICT)) ? PW'(MAX_PREDICT)
                                                                  : PW'(i_predict_count);
            r_k <= '0; r_i <= '0; r_pat <= PAT_RANDOM;
            r_seq <= 1'b0; r_bestc <= '0; r_best <= '0; r_rec <= '0;
        end
        if (i_cmd.clr_run) begin
            r_k <= '0; r_run <= CW'(1); r_c <= '0; r_j <= '0;
        end
        if (i_cmd.adv) r_k <= n_k;
        // sequential run and last position
        if (i_cmd.seq_acc) begin
            r_prev <= r_rpos;
            r_last <= r_rpos;
            if (r_k != '0) begin
                if (r_rpos == r_prev + 32'd1) begin
                    r_run <= r_run + CW'(1);
                    if (r_run + CW'(1) >= eff_min) r_seq <= 1'b1;
                end else r_run <= CW'(1);
            end
        end
        // outer candidate: positive step ending at entry k
        if (i_cmd.outer_acc) begin
            r_prev <= r_rpos;
            r_cand <= diff;
            r_lastpos_ok <= (r_k != '0) && (r_rpos > r_prev);
            r_c <= '0; r_j <= CW'(1);
            r_acc <= '0;
        end
        // inner: compare step ending at entry j-1 with candidate
        if (i_cmd.inner_acc) begin
            r_acc <= r_rpos;
            if (r_j != CW'(1) && r_rpos > r_acc && r_rpos - r_acc == r_cand)
                r_c <= r_c + CW'(1);
            r_j <= r_j + CW'(1);
        end
        if (i_cmd.outer_end) begin
            if (r_lastpos_ok && (r_c > r_bestc || (r_c == r_bestc && r_cand < r_best))) begin
                r_bestc <= r_c; r_best <= r_cand;
            end
        end
        if (i_cmd.temp_acc) begin
            if (is_recent) r_rec <= r_rec + CW'(1);
        end
        if (i_cmd.emit) begin
            r_i <= r_i + CW'(1);
            r_acc <= r_acc + r_best;
        end
        if (i_cmd.adv_outer) begin
            r_pat <= r_seq ? PAT_SEQ : (r_bestc != '0 && r_bestc >= eff_min) ? PAT_STRIDE
                   : PAT_TEMPORAL;
            r_acc <= r_last + (r_seq ? 32'd1 : r_best);
            r_n <= (!r_seq && !(r_bestc != '0 && r_bestc >= eff_min)
                    && 32'(r_want) > 32'(cnt)) ? PW'(cnt) : r_want;
            if (r_seq) r_best <= 32'd1;
            r_i <= '0;
        end
    end

    // emit path: temporal reads newest first; seq/stride use accumulator
    logic [31:0] pred;
    assign pred = (r_pat == PAT_TEMPORAL) ? r_rpos : r_acc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_position_valid <= 1'b0;
        else o_position_valid <= i_cmd.emit;
        o_pattern <= r_pat;
        o_predicted_position <= pred;
        o_last <= (MW'(r_i) + MW'(1) == MW'(r_n));
    end

    // status; the recent count takes in the entry being folded this cycle
    always_comb begin
        o_sts.too_short  = (cnt == '0) || (cnt < eff_min);
        o_sts.scan_done  = (n_k >= cnt);
        o_sts.outer_done = (n_k >= cnt);
        o_sts.inner_done = (r_j >= cnt);
        o_sts.seq_hit    = r_seq;
        o_sts.stride_hit = (r_bestc != '0) && (r_bestc >= eff_min);
        o_sts.temp_hit   = ((r_rec + CW'(is_recent)) >= eff_min);
        o_sts.emit_done  = (MW'(r_i) + MW'(1) >= MW'(r_n));
    end
endmodule
`default_nettype wire

### rtl/apd_ctrl.sv
// Controller: sequences record, clear and predict passes
`default_nettype none
module apd_ctrl import apd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_func,
    input  wire logic [2:0] i_session_index,
    input  wire logic [4:0] i_predict_count,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            o_busy
);
    t_state r_st, n_st;
    logic r_rec, r_clr, r_pred;
    logic go;
    assign go = i_start && !o_busy && (32'(i_session_index) < 32'(SESSIONS));
    assign o_busy = (r_st != ST_IDLE) || r_rec || r_clr || r_pred;

    // latch accepted function for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= 1'b0; r_clr <= 1'b0; r_pred <= 1'b0; r_st <= ST_IDLE;
        end else begin
            r_rec  <= go && i_func == FUNC_RECORD;
            r_clr  <= go && i_func == FUNC_RESET;
            r_pred <= go && i_func == FUNC_PREDICT && i_predict_count != 5'd0;
            r_st   <= n_st;
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:    if (r_pred && !i_sts.too_short) n_st = ST_SCAN;
            ST_SCAN:    n_st = ST_SCAN_W;
            ST_SCAN_W:  n_st = i_sts.scan_done ? ST_OUTER : ST_SCAN;
            ST_OUTER:   n_st = ST_OUTER_W;
            ST_OUTER_W: n_st = ST_INNER;
            ST_INNER:   n_st = ST_INNER_W;
            ST_INNER_W: n_st = i_sts.inner_done ? ST_DECIDE : ST_INNER;
            ST_DECIDE:  n_st = i_sts.outer_done ? ST_TEMP : ST_OUTER;
            ST_TEMP:    n_st = ST_TEMP_W;
            ST_TEMP_W:  if (!i_sts.scan_done) n_st = ST_TEMP;
                        else if (i_sts.seq_hit || i_sts.stride_hit || i_sts.temp_hit)
                            n_st = ST_EMIT;
                        else n_st = ST_IDLE;
            ST_EMIT:    n_st = ST_EMIT_W;
            ST_EMIT_W:  n_st = i_sts.emit_done ? ST_IDLE : ST_EMIT;
            default:    n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.load = go;
        o_cmd.do_record = r_rec;
        o_cmd.do_clear = r_clr;
        unique case (r_st)
            ST_IDLE:    o_cmd.clr_run = r_pred;
            ST_SCAN:    o_cmd.rd_req = 1'b1;
            ST_SCAN_W:  begin
                o_cmd.seq_acc = 1'b1;
                o_cmd.adv = !i_sts.scan_done;
                o_cmd.clr_run = i_sts.scan_done;
            end
            ST_OUTER:   o_cmd.rd_req = 1'b1;
            ST_OUTER_W: o_cmd.outer_acc = 1'b1;
            ST_INNER:   begin
                o_cmd.rd_req = 1'b1;
                o_cmd.rd_inner = 1'b1;
            end
            ST_INNER_W: o_cmd.inner_acc = 1'b1;
            ST_DECIDE:  begin
                o_cmd.outer_end = 1'b1;
                o_cmd.adv = !i_sts.outer_done;
                o_cmd.clr_run = i_sts.outer_done;
            end
            ST_TEMP:    o_cmd.rd_req = 1'b1;
            ST_TEMP_W:  begin
                o_cmd.temp_acc = 1'b1;
                o_cmd.adv = 1'b1;
                o_cmd.adv_outer = i_sts.scan_done;
            end
            ST_EMIT:    o_cmd.rd_req = 1'b1;
            ST_EMIT_W:  o_cmd.emit = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### rtl/access_pattern_detector_predictor_core.sv
// Top level: access pattern detector and predictor
// Record and slot clear run from the registered start; start is blocked by busy meanwhile.
// Predict walks the history with one memory read port: a sequential scan, an
// outer/inner stride search, a recent-entry scan, then one read per result beat.
// Results cannot be stalled; each beat is shown for one cycle on o_position_valid.
// Synchronous active-low reset clears slot counts and loads register defaults.
`default_nettype none
module access_pattern_detector_predictor_core import apd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [1:0]  i_func,
    input  wire logic [2:0]  i_session_index,
    input  wire logic [31:0] i_position,
    input  wire logic [4:0]  i_predict_count,
    input  wire logic [31:0] i_now_seconds,
    output logic [1:0]       o_pattern,
    output logic [31:0]      o_predicted_position,
    output logic             o_position_valid,
    output logic             o_last
);
    t_cmd cmd;
    t_sts sts;

    apd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_func, .i_session_index,
        .i_predict_count, .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    apd_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_session_index, .i_position, .i_predict_count, .i_now_seconds,
        .i_cmd(cmd), .o_sts(sts), .o_pattern, .o_predicted_position,
        .o_position_valid, .o_last
    );
endmodule
`default_nettype wire

### rtl/apd_checker.sv
// Port-level checker bound to the top level
`default_nettype none
`include "access_pattern_detector_predictor_core_defines.svh"
module apd_checker import apd_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_func,
    input wire logic [1:0] o_pattern,
    input wire logic       o_position_valid,
    input wire logic       o_last
);
    `APD_ASSERT_NEXT(a_busy_after_go, i_clk, i_rst_n, start && !busy && i_func == FUNC_RECORD, busy, "record without busy")
    `APD_ASSERT_IMPL(a_beat_busy, i_clk, i_rst_n, o_position_valid, busy || o_last, "beat while idle")
    `APD_ASSERT_IMPL(a_no_random, i_clk, i_rst_n, o_position_valid, o_pattern != PAT_RANDOM, "random beat")
    `APD_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_position_valid && o_last, !o_position_valid, "beat after last")
endmodule
bind access_pattern_detector_predictor_core apd_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .i_func, .o_pattern, .o_position_valid, .o_last
);
`default_nettype wire
